### rtl/sobfr_pkg.sv
// -----------------------------------------------------------------------------
// sobfr_pkg: shared types and constants for the substring order block
// Mode, order and kind codes, controller states, datapath commands and status.
// -----------------------------------------------------------------------------
`default_nettype none

package sobfr_pkg;

  // Default sizing
  localparam int unsigned DEF_MAX_LENGTH = 1024;
  localparam int unsigned DEF_LEVELS     = 11;
  localparam int unsigned DEF_RANK_WIDTH = 10;

  // Fixed field widths
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned LETTER_W = 5;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned ORDER_W  = 2;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BUILD  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

  // Result codes
  localparam logic KIND_BUILD = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [ORDER_W-1:0] ORDER_LESS    = 2'd0;
  localparam logic [ORDER_W-1:0] ORDER_EQUAL   = 2'd1;
  localparam logic [ORDER_W-1:0] ORDER_GREATER = 2'd2;
  localparam logic [ORDER_W-1:0] ORDER_INVALID = 2'd3;

  // Controller states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LEVEL,
    ST_LOAD_RD,
    ST_LOAD_WR,
    ST_SORT_INIT,
    ST_MERGE_CHK,
    ST_MERGE_RD,
    ST_MERGE_WR,
    ST_RANK_RD,
    ST_RANK_WR,
    ST_LEVEL_NEXT,
    ST_Q_CHECK,
    ST_Q_LOG,
    ST_Q_RD_A,
    ST_Q_RD_B,
    ST_Q_CMP,
    ST_DONE
  } state_e;

  // Datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_APPEND,
    OP_BUILD_START,
    OP_LEVEL_START,
    OP_BUILD_END,
    OP_LOAD_RD,
    OP_LOAD_WR,
    OP_SORT_START,
    OP_MERGE_RD,
    OP_MERGE_WR,
    OP_RANK_START,
    OP_RANK_RD,
    OP_RANK_WR,
    OP_LEVEL_NEXT,
    OP_Q_CAPTURE,
    OP_Q_CHECK,
    OP_Q_LOG,
    OP_Q_RD_A,
    OP_Q_RD_B,
    OP_Q_CMP,
    OP_OUT_LOAD
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic level_ok;
    logic load_last;
    logic sort_done;
    logic rank_last;
    logic q_invalid;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

### rtl/substring_order_by_factor_ranks.sv
// -----------------------------------------------------------------------------
// substring_order_by_factor_ranks: substring compare by basic-factor ranks
// Collects a word, builds the per-level rank table and answers order queries.
// -----------------------------------------------------------------------------
// An append item gives no result. A query item runs a range check (a failing one
// ends there), a block size step, paired reads from the rank table at the block
// start and at its offset, and a compare. A build item walks each level with n - 2^j + 1
// entries: a read and a write per entry to load pair keys, a merge sort with a
// check, a read and a write per entry per pass over ceil(log2(cnt)) passes, and a
// read and a write per entry to write dense ranks; the single write port and
// registered reads of the rank table and the two scratch memories set these steps.
// No clearing pass runs after reset. Appends are taken while a result waits at the output.
`default_nettype none

module substring_order_by_factor_ranks #(
  parameter int unsigned MAX_LENGTH = sobfr_pkg::DEF_MAX_LENGTH,
  parameter int unsigned LEVELS     = sobfr_pkg::DEF_LEVELS,
  parameter int unsigned RANK_WIDTH = sobfr_pkg::DEF_RANK_WIDTH
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [sobfr_pkg::MODE_W-1:0]   mode_i,
  input  wire logic [sobfr_pkg::LETTER_W-1:0] letter_i,
  input  wire logic [sobfr_pkg::POS_W-1:0]    first_start_i,
  input  wire logic [sobfr_pkg::POS_W-1:0]    first_end_i,
  input  wire logic [sobfr_pkg::POS_W-1:0]    second_start_i,
  input  wire logic [sobfr_pkg::POS_W-1:0]    second_end_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                kind_o,
  output logic [sobfr_pkg::ORDER_W-1:0]       order_o
);

  sobfr_pkg::cmd_t    cmd;
  sobfr_pkg::status_t status;

  // Sequencer
  sobfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Tables, counters and output register
  sobfr_dp #(
    .MAX_LENGTH (MAX_LENGTH),
    .LEVELS     (LEVELS),
    .RANK_WIDTH (RANK_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .letter_i       (letter_i),
    .first_start_i  (first_start_i),
    .first_end_i    (first_end_i),
    .second_start_i (second_start_i),
    .second_end_i   (second_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .order_o        (order_o)
  );

  // Load the output only when it is free
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == sobfr_pkg::OP_OUT_LOAD |-> status.out_free)
    else $error("output loaded while occupied");

  // A load shows a result next cycle
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == sobfr_pkg::OP_OUT_LOAD |=> out_valid_o)
    else $error("loaded result not shown");

  // While accepting, only item-start commands issue
  a_idle_ops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> (cmd.op == sobfr_pkg::OP_NONE || cmd.op == sobfr_pkg::OP_APPEND ||
                     cmd.op == sobfr_pkg::OP_BUILD_START ||
                     cmd.op == sobfr_pkg::OP_Q_CAPTURE))
    else $error("work command while idle");

endmodule

`default_nettype wire

### rtl/sobfr_ctrl.sv
// -----------------------------------------------------------------------------
// sobfr_ctrl: sequencing state machine
// Walks append, build (load, merge sort, rank) and query steps and issues one
// datapath command per cycle.
// -----------------------------------------------------------------------------
`default_nettype none

module sobfr_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic [sobfr_pkg::MODE_W-1:0]  mode_i,
  output logic                               in_stall_o,
  input  wire sobfr_pkg::status_t            status_i,
  output sobfr_pkg::cmd_t                    cmd_o
);

  sobfr_pkg::state_e state_q, state_d;
  logic              accept;

  assign in_stall_o = (state_q != sobfr_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // Advance state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sobfr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sobfr_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (mode_i)
            sobfr_pkg::MODE_BUILD: state_d = sobfr_pkg::ST_LEVEL;
            sobfr_pkg::MODE_QUERY: state_d = sobfr_pkg::ST_Q_CHECK;
            default:               state_d = sobfr_pkg::ST_IDLE;
          endcase
        end
      end
      sobfr_pkg::ST_LEVEL:
        state_d = status_i.level_ok ? sobfr_pkg::ST_LOAD_RD : sobfr_pkg::ST_DONE;
      sobfr_pkg::ST_LOAD_RD:   state_d = sobfr_pkg::ST_LOAD_WR;
      sobfr_pkg::ST_LOAD_WR:
        state_d = status_i.load_last ? sobfr_pkg::ST_SORT_INIT : sobfr_pkg::ST_LOAD_RD;
      sobfr_pkg::ST_SORT_INIT: state_d = sobfr_pkg::ST_MERGE_CHK;
      sobfr_pkg::ST_MERGE_CHK:
        state_d = status_i.sort_done ? sobfr_pkg::ST_RANK_RD : sobfr_pkg::ST_MERGE_RD;
      sobfr_pkg::ST_MERGE_RD:  state_d = sobfr_pkg::ST_MERGE_WR;
      sobfr_pkg::ST_MERGE_WR:  state_d = sobfr_pkg::ST_MERGE_CHK;
      sobfr_pkg::ST_RANK_RD:   state_d = sobfr_pkg::ST_RANK_WR;
      sobfr_pkg::ST_RANK_WR:
        state_d = status_i.rank_last ? sobfr_pkg::ST_LEVEL_NEXT : sobfr_pkg::ST_RANK_RD;
      sobfr_pkg::ST_LEVEL_NEXT: state_d = sobfr_pkg::ST_LEVEL;
      sobfr_pkg::ST_Q_CHECK:
        state_d = status_i.q_invalid ? sobfr_pkg::ST_DONE : sobfr_pkg::ST_Q_LOG;
      sobfr_pkg::ST_Q_LOG:     state_d = sobfr_pkg::ST_Q_RD_A;
      sobfr_pkg::ST_Q_RD_A:    state_d = sobfr_pkg::ST_Q_RD_B;
      sobfr_pkg::ST_Q_RD_B:    state_d = sobfr_pkg::ST_Q_CMP;
      sobfr_pkg::ST_Q_CMP:     state_d = sobfr_pkg::ST_DONE;
      sobfr_pkg::ST_DONE:
        state_d = status_i.out_free ? sobfr_pkg::ST_IDLE : sobfr_pkg::ST_DONE;
      default:                 state_d = sobfr_pkg::ST_IDLE;
    endcase
  end

  // Issue commands
  always_comb begin
    cmd_o.op = sobfr_pkg::OP_NONE;
    unique case (state_q)
      sobfr_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (mode_i)
            sobfr_pkg::MODE_APPEND: cmd_o.op = sobfr_pkg::OP_APPEND;
            sobfr_pkg::MODE_BUILD:  cmd_o.op = sobfr_pkg::OP_BUILD_START;
            sobfr_pkg::MODE_QUERY:  cmd_o.op = sobfr_pkg::OP_Q_CAPTURE;
            default:                cmd_o.op = sobfr_pkg::OP_NONE;
          endcase
        end
      end
      sobfr_pkg::ST_LEVEL:
        cmd_o.op = status_i.level_ok ? sobfr_pkg::OP_LEVEL_START : sobfr_pkg::OP_BUILD_END;
      sobfr_pkg::ST_LOAD_RD:   cmd_o.op = sobfr_pkg::OP_LOAD_RD;
      sobfr_pkg::ST_LOAD_WR:   cmd_o.op = sobfr_pkg::OP_LOAD_WR;
      sobfr_pkg::ST_SORT_INIT: cmd_o.op = sobfr_pkg::OP_SORT_START;
      sobfr_pkg::ST_MERGE_CHK:
        cmd_o.op = status_i.sort_done ? sobfr_pkg::OP_RANK_START : sobfr_pkg::OP_NONE;
      sobfr_pkg::ST_MERGE_RD:  cmd_o.op = sobfr_pkg::OP_MERGE_RD;
      sobfr_pkg::ST_MERGE_WR:  cmd_o.op = sobfr_pkg::OP_MERGE_WR;
      sobfr_pkg::ST_RANK_RD:   cmd_o.op = sobfr_pkg::OP_RANK_RD;
      sobfr_pkg::ST_RANK_WR:   cmd_o.op = sobfr_pkg::OP_RANK_WR;
      sobfr_pkg::ST_LEVEL_NEXT: cmd_o.op = sobfr_pkg::OP_LEVEL_NEXT;
      sobfr_pkg::ST_Q_CHECK:   cmd_o.op = sobfr_pkg::OP_Q_CHECK;
      sobfr_pkg::ST_Q_LOG:     cmd_o.op = sobfr_pkg::OP_Q_LOG;
      sobfr_pkg::ST_Q_RD_A:    cmd_o.op = sobfr_pkg::OP_Q_RD_A;
      sobfr_pkg::ST_Q_RD_B:    cmd_o.op = sobfr_pkg::OP_Q_RD_B;
      sobfr_pkg::ST_Q_CMP:     cmd_o.op = sobfr_pkg::OP_Q_CMP;
      sobfr_pkg::ST_DONE:
        cmd_o.op = status_i.out_free ? sobfr_pkg::OP_OUT_LOAD : sobfr_pkg::OP_NONE;
      default:                 cmd_o.op = sobfr_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

### rtl/sobfr_dp.sv
// -----------------------------------------------------------------------------
// sobfr_dp: rank table, sort scratch memories, counters and output register
// Executes one controller command per cycle.
// -----------------------------------------------------------------------------
`default_nettype none

module sobfr_dp #(
  parameter int unsigned MAX_LENGTH = sobfr_pkg::DEF_MAX_LENGTH,
  parameter int unsigned LEVELS     = sobfr_pkg::DEF_LEVELS,
  parameter int unsigned RANK_WIDTH = sobfr_pkg::DEF_RANK_WIDTH
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire sobfr_pkg::cmd_t                cmd_i,
  output sobfr_pkg::status_t                  status_o,
  input  wire logic [sobfr_pkg::LETTER_W-1:0] letter_i,
  input  wire logic [sobfr_pkg::POS_W-1:0]    first_start_i,
  input  wire logic [sobfr_pkg::POS_W-1:0]    first_end_i,
  input  wire logic [sobfr_pkg::POS_W-1:0]    second_start_i,
  input  wire logic [sobfr_pkg::POS_W-1:0]    second_end_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                kind_o,
  output logic [sobfr_pkg::ORDER_W-1:0]       order_o
);

  localparam int unsigned IW     = (MAX_LENGTH > 2) ? $clog2(MAX_LENGTH) : 1;
  localparam int unsigned LEN_W  = $clog2(MAX_LENGTH + 1);
  localparam int unsigned SW     = IW + 3;
  localparam int unsigned LVL_W  = $clog2(LEVELS);
  localparam int unsigned JW     = $clog2(LEVELS + 1);
  localparam int unsigned DEPTH  = LEVELS * MAX_LENGTH;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned KW     = 2 * RANK_WIDTH + IW;
  localparam int unsigned PW     = sobfr_pkg::POS_W;
  localparam int unsigned CW     = (LEN_W > PW) ? LEN_W : PW;
  localparam int unsigned LGW    = (LEN_W > 2) ? $clog2(LEN_W) : 1;

  // Memories
  logic [RANK_WIDTH-1:0] rt_mem [DEPTH];
  logic [KW-1:0]         sa_mem [MAX_LENGTH];
  logic [KW-1:0]         sb_mem [MAX_LENGTH];

  logic                  rt_we;
  logic [ADDR_W-1:0]     rt_waddr, rt_raddr0, rt_raddr1;
  logic [RANK_WIDTH-1:0] rt_wdata, rt_rd0_q, rt_rd1_q;
  logic                  sa_we, sb_we;
  logic [IW-1:0]         s_waddr;
  logic [KW-1:0]         s_wdata, sa_rd0_q, sa_rd1_q, sb_rd0_q, sb_rd1_q, s_rd0, s_rd1;

  // Word and build state
  logic [LEN_W-1:0]      wl_q;
  logic                  ready_q;
  logic [JW-1:0]         lvl_q;
  logic [LEN_W-1:0]      cnt_q;
  logic [SW-1:0]         half_q;
  logic [SW-1:0]         pi_q, pj_q, pk_q, lo_q, w_q, mid_q, hi_q;
  logic                  src_q;
  logic [RANK_WIDTH-1:0] rank_q;
  logic [2*RANK_WIDTH-1:0] prev_key_q;

  // Query state
  logic [PW-1:0]         s1_q, e1_q, s2_q, e2_q;
  logic [LEN_W-1:0]      len1_q, len2_q, off_q;
  logic [LVL_W-1:0]      lg_q;
  logic [RANK_WIDTH-1:0] a1_q, a2_q;
  logic                  res_kind_q;
  logic [sobfr_pkg::ORDER_W-1:0] res_order_q;
  logic                  out_valid_q, out_kind_q;
  logic [sobfr_pkg::ORDER_W-1:0] out_order_q;

  // Combinational helpers
  logic [LEN_W-1:0]      wl_eff, cnt_ext;
  logic [SW-1:0]         cnt_sw, lo_n, w_n, seg_base, mid_n, hi_n, sum_mid, sum_hi;
  logic                  pass_end, seg_end, take_i;
  logic [ADDR_W-1:0]     base_prev, base_cur, base_lg;
  logic                  q_invalid;
  logic [LEN_W-1:0]      m_len;
  logic [LGW-1:0]        lg_raw;
  logic [LVL_W-1:0]      lg_clamp;
  logic [2*RANK_WIDTH-1:0] key_cur;
  logic [RANK_WIDTH-1:0] rank_new;
  logic [sobfr_pkg::ORDER_W-1:0] cmp_order;

  assign cnt_sw = SW'(cnt_q);
  assign s_rd0  = src_q ? sb_rd0_q : sa_rd0_q;
  assign s_rd1  = src_q ? sb_rd1_q : sa_rd1_q;

  // Level bases in the rank table
  assign base_prev = ADDR_W'(lvl_q - JW'(1)) * ADDR_W'(MAX_LENGTH);
  assign base_cur  = ADDR_W'(lvl_q) * ADDR_W'(MAX_LENGTH);
  assign base_lg   = ADDR_W'(lg_q) * ADDR_W'(MAX_LENGTH);

  // Start a new word on append after a build
  assign wl_eff  = ready_q ? '0 : wl_q;
  assign cnt_ext = wl_q - (LEN_W'(1) << lvl_q) + LEN_W'(1);

  // Next merge segment
  assign lo_n     = lo_q + (w_q << 1);
  assign pass_end = (lo_n >= cnt_sw);
  assign w_n      = pass_end ? (w_q << 1) : w_q;
  assign seg_base = pass_end ? '0 : lo_n;
  assign sum_mid  = seg_base + w_n;
  assign sum_hi   = seg_base + (w_n << 1);
  assign mid_n    = (sum_mid < cnt_sw) ? sum_mid : cnt_sw;
  assign hi_n     = (sum_hi < cnt_sw) ? sum_hi : cnt_sw;
  assign seg_end  = (pk_q + SW'(1) == hi_q);
  assign take_i   = (pi_q < mid_q) && ((pj_q >= hi_q) || (s_rd0 <= s_rd1));

  // Dense rank of the next sorted key
  assign key_cur  = s_rd0[KW-1:IW];
  assign rank_new = (pi_q == '0) ? '0 :
                    ((key_cur != prev_key_q) ? rank_q + RANK_WIDTH'(1) : rank_q);

  // Query range check
  assign q_invalid = !ready_q || (s1_q > e1_q) || (s2_q > e2_q) ||
                     (CW'(e1_q) >= CW'(wl_q)) || (CW'(e2_q) >= CW'(wl_q));

  // Block size: highest set bit of the shorter length, clamped to the top level
  assign m_len = (len1_q < len2_q) ? len1_q : len2_q;
  always_comb begin
    lg_raw = '0;
    for (int b = 0; b < LEN_W; b++) begin
      if (m_len[b]) lg_raw = LGW'(b);
    end
    if (32'(lg_raw) > 32'(LEVELS - 1)) lg_clamp = LVL_W'(LEVELS - 1);
    else                               lg_clamp = LVL_W'(lg_raw);
  end

  // Compare first blocks, then second blocks, then lengths
  always_comb begin
    if (a1_q != a2_q)             cmp_order = (a1_q < a2_q) ? sobfr_pkg::ORDER_LESS
                                                            : sobfr_pkg::ORDER_GREATER;
    else if (rt_rd0_q != rt_rd1_q) cmp_order = (rt_rd0_q < rt_rd1_q) ? sobfr_pkg::ORDER_LESS
                                                                     : sobfr_pkg::ORDER_GREATER;
    else if (len1_q == len2_q)    cmp_order = sobfr_pkg::ORDER_EQUAL;
    else                          cmp_order = (len1_q < len2_q) ? sobfr_pkg::ORDER_LESS
                                                                : sobfr_pkg::ORDER_GREATER;
  end

  // Rank table port selection
  always_comb begin
    rt_we     = 1'b0;
    rt_waddr  = ADDR_W'(wl_eff);
    rt_wdata  = RANK_WIDTH'(letter_i);
    rt_raddr0 = base_prev + ADDR_W'(pi_q);
    rt_raddr1 = base_prev + ADDR_W'(pi_q + half_q);
    case (cmd_i.op)
      sobfr_pkg::OP_APPEND: rt_we = (wl_eff < LEN_W'(MAX_LENGTH));
      sobfr_pkg::OP_RANK_WR: begin
        rt_we    = 1'b1;
        rt_waddr = base_cur + ADDR_W'(s_rd0[IW-1:0]);
        rt_wdata = rank_new;
      end
      sobfr_pkg::OP_Q_RD_A: begin
        rt_raddr0 = base_lg + ADDR_W'(s1_q);
        rt_raddr1 = base_lg + ADDR_W'(s2_q);
      end
      sobfr_pkg::OP_Q_RD_B: begin
        rt_raddr0 = base_lg + ADDR_W'(s1_q) + ADDR_W'(off_q);
        rt_raddr1 = base_lg + ADDR_W'(s2_q) + ADDR_W'(off_q);
      end
      default: ;
    endcase
  end

  // Scratch port selection
  always_comb begin
    sa_we   = 1'b0;
    sb_we   = 1'b0;
    s_waddr = pk_q[IW-1:0];
    s_wdata = take_i ? s_rd0 : s_rd1;
    case (cmd_i.op)
      sobfr_pkg::OP_LOAD_WR: begin
        sa_we   = 1'b1;
        s_waddr = pi_q[IW-1:0];
        s_wdata = {rt_rd0_q, rt_rd1_q, pi_q[IW-1:0]};
      end
      sobfr_pkg::OP_MERGE_WR: begin
        sa_we = src_q;
        sb_we = !src_q;
      end
      default: ;
    endcase
  end

  // Rank table memory
  always_ff @(posedge clk_i) begin
    if (rt_we) rt_mem[rt_waddr] <= rt_wdata;
    rt_rd0_q <= rt_mem[rt_raddr0];
    rt_rd1_q <= rt_mem[rt_raddr1];
  end

  // Sort scratch memories, ping-pong between merge passes
  always_ff @(posedge clk_i) begin
    if (sa_we) sa_mem[s_waddr] <= s_wdata;
    sa_rd0_q <= sa_mem[pi_q[IW-1:0]];
    sa_rd1_q <= sa_mem[pj_q[IW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (sb_we) sb_mem[s_waddr] <= s_wdata;
    sb_rd0_q <= sb_mem[pi_q[IW-1:0]];
    sb_rd1_q <= sb_mem[pj_q[IW-1:0]];
  end

  // Word length and table ready flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q    <= '0;
      ready_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        sobfr_pkg::OP_APPEND: begin
          ready_q <= 1'b0;
          wl_q    <= (wl_eff < LEN_W'(MAX_LENGTH)) ? wl_eff + LEN_W'(1) : wl_eff;
        end
        sobfr_pkg::OP_BUILD_END: ready_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // Build counters
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      sobfr_pkg::OP_BUILD_START: lvl_q <= JW'(1);
      sobfr_pkg::OP_LEVEL_START: begin
        cnt_q  <= cnt_ext;
        half_q <= SW'(1) << (lvl_q - JW'(1));
        pi_q   <= '0;
      end
      sobfr_pkg::OP_LOAD_WR: pi_q <= pi_q + SW'(1);
      sobfr_pkg::OP_SORT_START: begin
        lo_q  <= '0;
        w_q   <= SW'(1);
        src_q <= 1'b0;
        pi_q  <= '0;
        pk_q  <= '0;
        pj_q  <= (cnt_sw > SW'(1)) ? SW'(1) : cnt_sw;
        mid_q <= (cnt_sw > SW'(1)) ? SW'(1) : cnt_sw;
        hi_q  <= (cnt_sw > SW'(2)) ? SW'(2) : cnt_sw;
      end
      sobfr_pkg::OP_MERGE_WR: begin
        if (seg_end) begin
          lo_q  <= seg_base;
          w_q   <= w_n;
          mid_q <= mid_n;
          hi_q  <= hi_n;
          pi_q  <= seg_base;
          pj_q  <= mid_n;
          pk_q  <= seg_base;
          if (pass_end) src_q <= !src_q;
        end else begin
          pk_q <= pk_q + SW'(1);
          if (take_i) pi_q <= pi_q + SW'(1);
          else        pj_q <= pj_q + SW'(1);
        end
      end
      sobfr_pkg::OP_RANK_START: pi_q <= '0;
      sobfr_pkg::OP_RANK_WR: begin
        rank_q     <= rank_new;
        prev_key_q <= key_cur;
        pi_q       <= pi_q + SW'(1);
      end
      sobfr_pkg::OP_LEVEL_NEXT: lvl_q <= lvl_q + JW'(1);
      default: ;
    endcase
  end

  // Query registers and result
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      sobfr_pkg::OP_Q_CAPTURE: begin
        s1_q       <= first_start_i;
        e1_q       <= first_end_i;
        s2_q       <= second_start_i;
        e2_q       <= second_end_i;
        res_kind_q <= sobfr_pkg::KIND_QUERY;
      end
      sobfr_pkg::OP_Q_CHECK: begin
        len1_q      <= LEN_W'(CW'(e1_q) - CW'(s1_q) + CW'(1));
        len2_q      <= LEN_W'(CW'(e2_q) - CW'(s2_q) + CW'(1));
        res_order_q <= sobfr_pkg::ORDER_INVALID;
      end
      sobfr_pkg::OP_Q_LOG: begin
        lg_q  <= lg_clamp;
        off_q <= m_len - (LEN_W'(1) << lg_clamp);
      end
      sobfr_pkg::OP_Q_RD_B: begin
        a1_q <= rt_rd0_q;
        a2_q <= rt_rd1_q;
      end
      sobfr_pkg::OP_Q_CMP: res_order_q <= cmp_order;
      sobfr_pkg::OP_BUILD_END: begin
        res_kind_q  <= sobfr_pkg::KIND_BUILD;
        res_order_q <= sobfr_pkg::ORDER_LESS;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == sobfr_pkg::OP_OUT_LOAD) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == sobfr_pkg::OP_OUT_LOAD) begin
      out_kind_q  <= res_kind_q;
      out_order_q <= res_order_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign order_o     = out_order_q;

  // Status to the controller
  assign status_o.level_ok  = (32'(lvl_q) < 32'(LEVELS)) && ((wl_q >> lvl_q) != '0);
  assign status_o.load_last = (pi_q + SW'(1) == cnt_sw);
  assign status_o.sort_done = (w_q >= cnt_sw);
  assign status_o.rank_last = (pi_q + SW'(1) == cnt_sw);
  assign status_o.q_invalid = q_invalid;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

endmodule

`default_nettype wire

### tb/sv/tb_substring_order_by_factor_ranks.sv
// -----------------------------------------------------------------------------
// tb_substring_order_by_factor_ranks: self-checking bench for substring order
// Drives append, build and compare items from a queue. A local rank-table model
// predicts every result, and a monitor checks each result against it under
// random idle and stall phases.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_substring_order_by_factor_ranks;

  localparam int unsigned MAXLEN   = sobfr_pkg::DEF_MAX_LENGTH;
  localparam int unsigned NLEVELS  = sobfr_pkg::DEF_LEVELS;
  localparam int unsigned RW       = sobfr_pkg::DEF_RANK_WIDTH;
  localparam int unsigned LTR_W    = sobfr_pkg::LETTER_W;
  localparam int unsigned PW       = sobfr_pkg::POS_W;
  localparam int unsigned N_ITEMS  = 1750;
  localparam int unsigned MAX_CYC  = 4000000;
  localparam int unsigned DRAIN    = 50;
  localparam int unsigned HOLD_LEN = 400;
  localparam logic [sobfr_pkg::MODE_W-1:0] MODE_NOP = 2'd3;

  typedef struct packed {
    logic [sobfr_pkg::MODE_W-1:0]   mode;
    logic [sobfr_pkg::LETTER_W-1:0] letter;
    logic [sobfr_pkg::POS_W-1:0]    s1;
    logic [sobfr_pkg::POS_W-1:0]    e1;
    logic [sobfr_pkg::POS_W-1:0]    s2;
    logic [sobfr_pkg::POS_W-1:0]    e2;
  } cmd_item_t;

  typedef struct packed {
    logic                          kind;
    logic [sobfr_pkg::ORDER_W-1:0] order;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [sobfr_pkg::MODE_W-1:0] mode_i = '0;
  logic [sobfr_pkg::LETTER_W-1:0] letter_i = '0;
  logic [sobfr_pkg::POS_W-1:0] first_start_i = '0;
  logic [sobfr_pkg::POS_W-1:0] first_end_i = '0;
  logic [sobfr_pkg::POS_W-1:0] second_start_i = '0;
  logic [sobfr_pkg::POS_W-1:0] second_end_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic kind_o;
  logic [sobfr_pkg::ORDER_W-1:0] order_o;

  substring_order_by_factor_ranks dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .mode_i, .letter_i,
    .first_start_i, .first_end_i, .second_start_i, .second_end_i,
    .out_valid_o, .out_stall_i, .kind_o, .order_o
  );

  // Model state
  logic [RW-1:0] rank_mem [NLEVELS][MAXLEN];
  int unsigned   word_len = 0;
  bit            tbl_ready = 1'b0;

  cmd_item_t pending_q [$];
  answer_t   answer_q [$];
  int unsigned total_items, taken_cnt = 0, results_cnt = 0, errors = 0;
  int unsigned n_append = 0, n_build = 0, n_query = 0, n_invalid = 0;
  int unsigned cycles = 0, gen_len = 0;
  bit gen_ready = 1'b0, pause_done = 1'b0, hold_done = 1'b0;
  int unsigned hold_left = 0;

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Fill each level of the rank table that fits the current word
  task automatic build_ranks();
    int unsigned half, cnt, r;
    int keys [$];
    int sorted [$];
    int rank_of [int];
    for (int unsigned j = 1; j < NLEVELS && (1 << j) <= word_len; j++) begin
      half = 1 << (j - 1);
      cnt = word_len - (1 << j) + 1;
      keys.delete();
      rank_of.delete();
      for (int unsigned i = 0; i < cnt; i++)
        keys.insert(keys.size(),
                    (int'(rank_mem[j-1][i]) << RW) | int'(rank_mem[j-1][i+half]));
      sorted = keys;
      sorted.sort();
      r = 0;
      foreach (sorted[i]) begin
        if (i > 0 && sorted[i] != sorted[i-1]) r++;
        rank_of[sorted[i]] = r;
      end
      for (int unsigned i = 0; i < cnt; i++) rank_mem[j][i] = RW'(rank_of[keys[i]]);
    end
    tbl_ready = 1'b1;
  endtask

  // Order of two substrings from their covering block ranks
  function automatic logic [sobfr_pkg::ORDER_W-1:0] substring_order(cmd_item_t it);
    int unsigned len1, len2, m, lg, off;
    logic [RW-1:0] a1, b1, a2, b2;
    if (!tbl_ready || it.s1 > it.e1 || it.s2 > it.e2 || it.e1 >= word_len ||
        it.e2 >= word_len) return sobfr_pkg::ORDER_INVALID;
    len1 = it.e1 - it.s1 + 1;
    len2 = it.e2 - it.s2 + 1;
    m = (len1 < len2) ? len1 : len2;
    lg = 0;
    while ((m >> (lg + 1)) != 0) lg++;
    if (lg > NLEVELS - 1) lg = NLEVELS - 1;
    off = m - (1 << lg);
    a1 = rank_mem[lg][it.s1];
    b1 = rank_mem[lg][it.s1 + off];
    a2 = rank_mem[lg][it.s2];
    b2 = rank_mem[lg][it.s2 + off];
    if (a1 != a2) return (a1 < a2) ? sobfr_pkg::ORDER_LESS : sobfr_pkg::ORDER_GREATER;
    if (b1 != b2) return (b1 < b2) ? sobfr_pkg::ORDER_LESS : sobfr_pkg::ORDER_GREATER;
    if (len1 == len2) return sobfr_pkg::ORDER_EQUAL;
    return (len1 < len2) ? sobfr_pkg::ORDER_LESS : sobfr_pkg::ORDER_GREATER;
  endfunction

  // Update the model with one accepted item and queue its answer
  task automatic apply_item(cmd_item_t it);
    answer_t ans;
    case (it.mode)
      sobfr_pkg::MODE_APPEND: begin
        n_append++;
        if (tbl_ready) begin
          tbl_ready = 1'b0;
          word_len = 0;
        end
        if (word_len < MAXLEN) begin
          rank_mem[0][word_len] = RW'(it.letter);
          word_len++;
        end
      end
      sobfr_pkg::MODE_BUILD: begin
        n_build++;
        build_ranks();
        ans.kind = sobfr_pkg::KIND_BUILD;
        ans.order = sobfr_pkg::ORDER_LESS;
        answer_q.insert(answer_q.size(), ans);
      end
      sobfr_pkg::MODE_QUERY: begin
        n_query++;
        ans.kind = sobfr_pkg::KIND_QUERY;
        ans.order = substring_order(it);
        if (ans.order == sobfr_pkg::ORDER_INVALID) n_invalid++;
        answer_q.insert(answer_q.size(), ans);
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    errors++;
    $display("MISMATCH result %0d: %s got %0d expected %0d", results_cnt, what, got, want);
  endtask

  // Stimulus builders; the generator tracks word length to aim queries
  task automatic push_item(logic [sobfr_pkg::MODE_W-1:0] md, int ltr,
                           int s1, int e1, int s2, int e2);
    cmd_item_t it;
    it.mode = md;
    it.letter = LTR_W'(ltr);
    it.s1 = PW'(s1);
    it.e1 = PW'(e1);
    it.s2 = PW'(s2);
    it.e2 = PW'(e2);
    pending_q.insert(pending_q.size(), it);
    if (md == sobfr_pkg::MODE_APPEND) begin
      if (gen_ready) begin
        gen_ready = 1'b0;
        gen_len = 0;
      end
      if (gen_len < MAXLEN) gen_len++;
    end else if (md == sobfr_pkg::MODE_BUILD) begin
      gen_ready = 1'b1;
    end
  endtask

  task automatic push_append(int ltr);
    push_item(sobfr_pkg::MODE_APPEND, ltr, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic push_query_in_word();
    int s1, e1, s2, e2;
    if (gen_len == 0 || $urandom_range(0, 9) == 0) begin
      push_item(sobfr_pkg::MODE_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      s1 = $urandom_range(0, gen_len - 1);
      e1 = $urandom_range(s1, gen_len - 1);
      s2 = $urandom_range(0, gen_len - 1);
      e2 = ($urandom_range(0, 2) == 0 && s2 + e1 - s1 < gen_len) ? s2 + e1 - s1
         : $urandom_range(s2, gen_len - 1);
      push_item(sobfr_pkg::MODE_QUERY, $urandom, s1, e1, s2, e2);
    end
  endtask

  // Fill the pending queue
  initial begin
    int unsigned len, top, nq;
    bit big_done;
    big_done = 1'b0;
    // Query before any build, build of an empty word, ignored mode
    push_item(sobfr_pkg::MODE_QUERY, 0, 0, 0, 0, 0);
    push_item(sobfr_pkg::MODE_BUILD, 0, 0, 0, 0, 0);
    push_item(sobfr_pkg::MODE_QUERY, 31, 0, 0, 0, 0);
    push_item(MODE_NOP, 31, 1023, 1023, 1023, 1023);
    // Short word with letters above 25
    push_append(0); push_append(31); push_append(25); push_append(0); push_append(31);
    push_item(sobfr_pkg::MODE_QUERY, 0, 0, 1, 0, 1);
    push_item(sobfr_pkg::MODE_BUILD, 0, 0, 0, 0, 0);
    push_item(sobfr_pkg::MODE_QUERY, 0, 0, 4, 0, 4);
    push_item(sobfr_pkg::MODE_QUERY, 0, 0, 0, 1, 1);
    push_item(sobfr_pkg::MODE_QUERY, 0, 1, 1, 0, 0);
    push_item(sobfr_pkg::MODE_QUERY, 0, 0, 1, 3, 4);
    push_item(sobfr_pkg::MODE_QUERY, 0, 0, 0, 3, 4);
    push_item(sobfr_pkg::MODE_QUERY, 0, 1, 4, 1, 2);
    push_item(sobfr_pkg::MODE_QUERY, 0, 3, 2, 0, 0);
    push_item(sobfr_pkg::MODE_QUERY, 0, 0, 5, 0, 0);
    push_item(sobfr_pkg::MODE_QUERY, 0, 1023, 1023, 0, 0);
    push_item(sobfr_pkg::MODE_QUERY, 31, 0, 4, 1023, 1023);
    push_item(sobfr_pkg::MODE_BUILD, 0, 0, 0, 0, 0);
    push_item(sobfr_pkg::MODE_QUERY, 0, 2, 3, 2, 4);

    // Random words, builds and queries, with one word past capacity
    while (pending_q.size() < N_ITEMS) begin
      if (!big_done && pending_q.size() > N_ITEMS / 3) begin
        big_done = 1'b1;
        for (int i = 0; i < MAXLEN + 4; i++) push_append($urandom_range(0, 1));
        push_item(sobfr_pkg::MODE_BUILD, 0, 0, 0, 0, 0);
        push_item(sobfr_pkg::MODE_QUERY, 0, 0, MAXLEN - 1, 0, MAXLEN - 1);
        push_item(sobfr_pkg::MODE_QUERY, 0, 0, MAXLEN - 1, 1, MAXLEN - 1);
        for (int i = 0; i < 30; i++) push_query_in_word();
      end else begin
        len = $urandom_range(1, 32);
        case ($urandom_range(0, 2))
          0: top = 1;
          1: top = 3;
          default: top = 31;
        endcase
        for (int unsigned i = 0; i < len; i++) begin
          push_append($urandom_range(0, top));
          if ($urandom_range(0, 19) == 0) begin
            if ($urandom_range(0, 1)) push_item(MODE_NOP, $urandom, $urandom, $urandom,
                                                $urandom, $urandom);
            else push_query_in_word();
          end
        end
        push_item(sobfr_pkg::MODE_BUILD, $urandom, $urandom, $urandom, $urandom, $urandom);
        nq = $urandom_range(4, 16);
        for (int unsigned i = 0; i < nq; i++) begin
          push_query_in_word();
          if ($urandom_range(0, 29) == 0) push_item(sobfr_pkg::MODE_BUILD, 0, 0, 0, 0, 0);
        end
      end
    end
    total_items = pending_q.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the stimulus to go out and every answer to come back
    wait (pending_q.size() == 0 && !in_valid_i);
    wait (answer_q.size() == 0);
    repeat (DRAIN) @(posedge clk_i);
    $display("Covered %0d appends, %0d builds, %0d queries (%0d invalid) in %0d cycles",
             n_append, n_build, n_query, n_invalid, cycles);
    $display("Checked %0d results with %0d mismatches", results_cnt, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Idle phase from progress: none, sender idle, receiver stall, both
  function automatic int unsigned phase_now();
    if (total_items == 0) return 0;
    return (taken_cnt * 8 / total_items) % 4;
  endfunction

  // Drive items; hold the payload while stalled
  always @(posedge clk_i) begin
    bit idle;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        apply_item({mode_i, letter_i, first_start_i, first_end_i, second_start_i,
                    second_end_i});
        taken_cnt++;
      end
      if (!in_valid_i || !in_stall_o) begin
        case (phase_now())
          1: idle = ($urandom_range(0, 99) < 86);
          3: idle = ($urandom_range(0, 99) < 38);
          default: idle = 1'b0;
        endcase
        // Pause once until every expected result has arrived
        if (!pause_done && taken_cnt >= total_items / 2) begin
          if (answer_q.size() == 0) pause_done = 1'b1;
          else idle = 1'b1;
        end
        if (pending_q.size() != 0 && !idle) begin
          {mode_i, letter_i, first_start_i, first_end_i, second_start_i,
           second_end_i} <= pending_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Check results and drive the output stall
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (answer_q.size() == 0) begin
          report_mismatch("unexpected result, kind", kind_o, 0);
        end else begin
          want = answer_q.pop_front();
          if (kind_o !== want.kind) report_mismatch("kind", kind_o, want.kind);
          if (order_o !== want.order) report_mismatch("order", order_o, want.order);
        end
        results_cnt++;
      end
      // Long hold-off once so the block backs up into its input
      if (!hold_done && results_cnt >= 150) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (phase_now())
          2: out_stall_i <= ($urandom_range(0, 99) < 86);
          3: out_stall_i <= ($urandom_range(0, 99) < 38);
          default: out_stall_i <= 1'b0;
        endcase
      end
    end
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MAX_CYC) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles,
               answer_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule

### substring_order_by_factor_ranks.f
rtl/sobfr_pkg.sv
rtl/sobfr_ctrl.sv
rtl/sobfr_dp.sv
rtl/substring_order_by_factor_ranks.sv
tb/sv/tb_substring_order_by_factor_ranks.sv
